### src/md5bh_pkg.sv
// Shared types, constants and step tables for the MD5 block hash core.
// Used by md5bh_compress and md5_block_hash_core; depends on nothing else.
package md5bh_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam int BLOCK_WORDS = 16;
  localparam int WORD_BITS   = 32;

  typedef enum logic [1:0] {
    T_IDLE,
    T_COMP,
    T_OUT
  } top_state_t;

  typedef enum logic {
    C_IDLE,
    C_RUN
  } cmp_state_t;

  typedef struct packed {
    logic start;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Message word used by step i; all index arithmetic is mod 16.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'((lo << 2) + lo + 4'd1);
      2'd2:    idx = 4'((lo << 1) + lo + 4'd5);
      2'd3:    idx = 4'((lo << 3) - lo);
      default: idx = lo;
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

### src/md5bh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module md5bh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/md5bh_compress.sv
// MD5 compression sequencer: one of the 64 steps per cycle, each message word
// read from the block RAM in the cycle before its step. Depends on md5bh_pkg.
module md5bh_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  md5bh_pkg::cmp_ctrl_t  ctrl,
  output md5bh_pkg::cmp_stat_t  stat,
  input  logic [31:0]           init_a,
  input  logic [31:0]           init_b,
  input  logic [31:0]           init_c,
  input  logic [31:0]           init_d,
  output logic [3:0]            rd_addr,
  input  logic [31:0]           rd_data,
  output logic [31:0]           res_a,
  output logic [31:0]           res_b,
  output logic [31:0]           res_c,
  output logic [31:0]           res_d
);
  import md5bh_pkg::*;

  cmp_state_t  state, state_next;
  logic [5:0]  step;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] new_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    stat.busy  = 1'b0;
    stat.done  = 1'b0;
    rd_addr    = msg_index(6'd0);
    case (state)
      C_IDLE: begin
        if (ctrl.start) begin
          state_next = C_RUN;
        end
      end
      C_RUN: begin
        stat.busy = 1'b1;
        rd_addr   = msg_index(step + 6'd1);
        if (step == 6'd63) begin
          stat.done  = 1'b1;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    case (step[5:4])
      2'd0:    f = (wb & wc) | (~wb & wd);
      2'd1:    f = (wb & wd) | (wc & ~wd);
      2'd2:    f = wb ^ wc ^ wd;
      2'd3:    f = wc ^ (wb | ~wd);
      default: f = wb ^ wc ^ wd;
    endcase
    sum   = wa + f + round_const(step) + rd_data;
    new_b = wb + rotl32(sum, rot_amt(step));
  end

  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctrl.start) begin
      step <= 6'd0;
      wa   <= init_a;
      wb   <= init_b;
      wc   <= init_c;
      wd   <= init_d;
    end else if (state == C_RUN) begin
      step <= step + 6'd1;
      wa   <= wd;
      wb   <= new_b;
      wc   <= wb;
      wd   <= wc;
    end
  end

  assign res_a = wa;
  assign res_b = wb;
  assign res_c = wc;
  assign res_d = wd;

endmodule

### src/md5_block_hash_core.sv
// MD5 block hash core, top level: byte packing, block RAM, chaining words,
// byte counter and result register. Depends on md5bh_pkg, md5bh_ram and
// md5bh_compress.
//
// Usage: message bytes enter on in_valid/in_ready with data_byte and
// restart; restart set reloads the standard initial chaining words and
// clears the byte count before its own byte is taken. Every fourth byte
// writes one little-endian word into a 16-word block RAM. The transaction
// that carries the 64th byte of a block starts the compression, which runs
// one step per cycle, reading each message word from the RAM port in the
// cycle before its step. The T_OUT state then adds the result to the
// chaining words and loads the output register; in_ready stays low from
// the last byte of a block until that load, so no byte is taken while a
// block is compressed. Bytes are taken while an earlier result still waits
// in the output register; if the receiver still stalls when the next block
// is compressed, the core waits in T_OUT until the register is free. Reset
// loads the initial chaining words, clears the count and empties the output
// register; the block RAM is not cleared.
module md5_block_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d,
  output logic [63:0] bytes_seen
);
  import md5bh_pkg::*;

  top_state_t  state, state_next;
  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [63:0] byte_count;
  logic [63:0] count_base;
  logic [5:0]  slot;
  logic [23:0] wbuf;
  logic        in_take;
  logic        ram_we;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [31:0] res_a, res_b, res_c, res_d;
  logic        out_load;

  assign in_ready   = (state == T_IDLE);
  assign in_take    = in_valid && in_ready;
  assign count_base = restart ? 64'd0 : byte_count;
  assign slot       = count_base[5:0];
  assign ram_we     = in_take && (slot[1:0] == 2'd3);
  assign cmp_ctrl.start = in_take && (slot == 6'd63);
  assign out_load   = (state == T_OUT) && (!out_valid || out_ready);

  md5bh_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot[5:2]),
    .wdata ({data_byte, wbuf}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md5bh_compress u_compress (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cmp_ctrl),
    .stat    (cmp_stat),
    .init_a  (chain_a),
    .init_b  (chain_b),
    .init_c  (chain_c),
    .init_d  (chain_d),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata),
    .res_a   (res_a),
    .res_b   (res_b),
    .res_c   (res_c),
    .res_d   (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (cmp_ctrl.start) begin
          state_next = T_COMP;
        end
      end
      T_COMP: begin
        if (cmp_stat.done) begin
          state_next = T_OUT;
        end
      end
      T_OUT: begin
        if (out_load) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_a    <= IV_A;
      chain_b    <= IV_B;
      chain_c    <= IV_C;
      chain_d    <= IV_D;
      byte_count <= 64'd0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        byte_count <= count_base + 64'd1;
        if (restart) begin
          chain_a <= IV_A;
          chain_b <= IV_B;
          chain_c <= IV_C;
          chain_d <= IV_D;
        end
      end
      if (out_load) begin
        chain_a   <= chain_a + res_a;
        chain_b   <= chain_b + res_b;
        chain_c   <= chain_c + res_c;
        chain_d   <= chain_d + res_d;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The low three bytes of a word wait here until its top byte arrives.
  always_ff @(posedge clk) begin
    if (in_take) begin
      case (slot[1:0])
        2'd0:    wbuf[7:0]   <= data_byte;
        2'd1:    wbuf[15:8]  <= data_byte;
        2'd2:    wbuf[23:16] <= data_byte;
        default: wbuf        <= wbuf;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_a   <= chain_a + res_a;
      digest_b   <= chain_b + res_b;
      digest_c   <= chain_c + res_c;
      digest_d   <= chain_d + res_d;
      bytes_seen <= byte_count;
    end
  end

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmp_stat.busy)
    else $error("input accepted while compression runs");

  a_done_in_comp: assert property (@(posedge clk) disable iff (rst)
    cmp_stat.done |-> (state == T_COMP))
    else $error("compression finished outside the compress state");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    cmp_ctrl.start |=> cmp_stat.busy)
    else $error("compression did not start after the last byte of a block");

  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (state != T_IDLE) |-> (byte_count[5:0] == 6'd0))
    else $error("compression running on an incomplete block");

endmodule

### sim/md5_digest_checker.sv
// Scoreboard for the MD5 block hash core: watches the byte and digest channels,
// folds every completed 64-byte block into its own chaining words and compares.
// Stands alone; needs only the port signals of md5_block_hash_core.
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] digest_a,
  input  logic [31:0] digest_b,
  input  logic [31:0] digest_c,
  input  logic [31:0] digest_d,
  input  logic [63:0] bytes_seen,
  output int unsigned mismatches,
  output int unsigned awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [63:0] total;
  } digest_t;

  localparam digest_t START_CHAIN = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                      32'h10325476, 64'd0};

  // Step constants, step 0 in the top word.
  localparam logic [64*32-1:0] STEP_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotation amounts: four per round, first entry in the top bits.
  localparam logic [16*5-1:0] STEP_SHIFT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  digest_t     chain;
  logic [511:0] block_bits;
  logic [63:0] byte_total;
  digest_t     pending_digests[$];
  digest_t     want;
  int unsigned fail_tally = 0;

  // One MD5 compression of a 64-byte block; byte j sits at bits 8j and up,
  // so each 32-bit slice is already the little-endian message word.
  function automatic digest_t fold_block(input digest_t prev, input logic [511:0] blk);
    logic [31:0] a, b, c, d, f, t, sum, rot;
    int unsigned g, s, rnd;
    digest_t next;
    a = prev.a;
    b = prev.b;
    c = prev.c;
    d = prev.d;
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = 32'(STEP_SHIFT[(15 - (rnd * 4 + i % 4)) * 5 +: 5]);
      sum = a + f + STEP_K[(63 - i) * 32 +: 32] + blk[g * 32 +: 32];
      rot = (sum << s) | (sum >> (32 - s));
      t = d;
      d = c;
      c = b;
      b = b + rot;
      a = t;
    end
    next = prev;
    next.a = prev.a + a;
    next.b = prev.b + b;
    next.c = prev.c + c;
    next.d = prev.d + d;
    return next;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %h, actual %h", name, exp_val, got_val);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chain = START_CHAIN;
      byte_total = '0;
      pending_digests.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          $error("digest transaction with none expected, bytes_seen %0d", bytes_seen);
          fail_tally++;
        end else begin
          want = pending_digests.pop_front();
          check_field("digest_a", 64'(want.a), 64'(digest_a));
          check_field("digest_b", 64'(want.b), 64'(digest_b));
          check_field("digest_c", 64'(want.c), 64'(digest_c));
          check_field("digest_d", 64'(want.d), 64'(digest_d));
          check_field("bytes_seen", want.total, bytes_seen);
        end
      end
      if (in_valid && in_ready) begin
        if (restart) begin
          chain = START_CHAIN;
          byte_total = '0;
        end
        block_bits[byte_total[5:0] * 8 +: 8] = data_byte;
        byte_total = byte_total + 64'd1;
        if (byte_total[5:0] == 6'd0) begin
          chain = fold_block(chain, block_bits);
          chain.total = byte_total;
          pending_digests.push_back(chain);
        end
      end
    end
    mismatches <= fail_tally;
    awaited <= pending_digests.size();
  end

endmodule

### sim/md5_block_hash_core_tb.sv
// Top of the MD5 block hash core testbench: clock, reset, byte stimulus with
// random gaps, a stalling digest receiver and the verdict. Depends on
// md5_block_hash_core and md5_digest_checker.
module md5_block_hash_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES,
    FILL_COUNT
  } fill_t;

  localparam int unsigned DIRECTED_ITEMS = 13;
  localparam int unsigned RANDOM_ITEMS   = 1900 - DIRECTED_ITEMS;
  localparam int unsigned MIN_BLOCKS     = 24;
  localparam int unsigned HOLD_AT        = 3000;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned DRAIN_CYCLES   = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;
  logic [63:0] bytes_seen;
  int unsigned mismatches;
  int unsigned awaited;

  // Byte position within the current block and blocks completed so far.
  int unsigned pos = 0;
  int unsigned blocks = 0;
  bit          quiet = 1'b0;

  always #10 clk = ~clk;

  md5_block_hash_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d),
    .bytes_seen (bytes_seen)
  );

  md5_digest_checker digest_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_a   (digest_a),
    .digest_b   (digest_b),
    .digest_c   (digest_c),
    .digest_d   (digest_d),
    .bytes_seen (bytes_seen),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic offer(input logic [7:0] value, input logic fresh);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    restart <= fresh;
    do @(posedge clk); while (!in_ready);
    pos = fresh ? 1 : (pos + 1) % 64;
    if (pos == 0) blocks++;
  endtask

  // Digest receiver: random stalls, long ready stretches, and one long hold-off
  // that lets the core fill up and push back on the byte side.
  initial begin : digest_receiver
    int unsigned cycles;
    int unsigned len;
    int unsigned roll;
    bit held;
    cycles = 0;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && cycles >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cycles += HOLD_CYCLES;
        held = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          out_ready <= 1'b1;
          len = $urandom_range(100, 300);
        end else if (roll < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 30);
        end else begin
          out_ready <= 1'b0;
          roll = $urandom_range(0, 99);
          if (roll < 80) len = $urandom_range(1, 3);
          else if (roll < 97) len = $urandom_range(4, 15);
          else len = $urandom_range(30, 60);
        end
        repeat (len) @(posedge clk);
        cycles += len;
      end
    end
  end

  initial begin : byte_source
    int unsigned sent;
    int unsigned roll;
    int unsigned slot;
    logic fresh;
    logic [7:0] value;
    fill_t fill;
    sent = 0;
    fill = FILL_RANDOM;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Byte extremes, a restart on the very first byte, a restart in the
    // middle of a block that drops the partial block, and one more restart
    // carrying an all-ones byte.
    offer(8'h00, 1'b1);
    offer(8'hff, 1'b0);
    offer(8'h80, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h7f, 1'b0);
    offer(8'hfe, 1'b0);
    offer(8'h55, 1'b1);
    offer(8'haa, 1'b0);
    offer(8'h00, 1'b0);
    offer(8'hff, 1'b0);
    offer(8'h0f, 1'b0);
    offer(8'hf0, 1'b0);
    offer(8'hff, 1'b1);

    // Mostly whole blocks chained into long messages; now and then a new
    // message at a block boundary, rarely a restart that breaks a block.
    while (sent < RANDOM_ITEMS || blocks < MIN_BLOCKS) begin
      roll = $urandom_range(0, 999);
      fresh = (pos == 0 && roll < 150) || (pos != 0 && roll < 3);
      slot = fresh ? 0 : pos;
      if (slot == 0) begin
        roll = $urandom_range(0, 9);
        fill = roll < 7 ? FILL_RANDOM : roll == 7 ? FILL_ZERO :
               roll == 8 ? FILL_ONES : FILL_COUNT;
        quiet = ($urandom_range(0, 3) == 0);
      end
      case (fill)
        FILL_ZERO:  value = 8'h00;
        FILL_ONES:  value = 8'hff;
        FILL_COUNT: value = 8'(slot);
        default:    value = 8'($urandom_range(0, 255));
      endcase
      offer(value, fresh);
      sent++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS md5_block_hash_core");
    end else begin
      $display("FAIL md5_block_hash_core");
    end
    $finish;
  end

  initial begin : watchdog
    #8ms;
    $display("FAIL md5_block_hash_core");
    $finish;
  end

endmodule
